// ===== rtl/order_statistic_multiset_defines.svh =====
// Assertion macros used by the port-level checker.
`ifndef ORDER_STATISTIC_MULTISET_DEFINES_SVH
`define ORDER_STATISTIC_MULTISET_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define OSM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define OSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/osm_pkg.sv =====
// Shared types and constants for the order statistic multiset.
package osm_pkg;
   localparam int unsigned Capacity = 1024;
   localparam int unsigned AddrWidth = $clog2(Capacity);
   localparam int unsigned CountWidth = $clog2(Capacity + 1);
   localparam logic signed [31:0] TopSentinel = 32'sh7fffffff;
   localparam logic signed [31:0] BottomSentinel = -32'sh7fffffff;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_RANK   = 2'd1,
      OP_SELECT = 2'd2,
      OP_NEIGH  = 2'd3
   } opcode_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic capture;     // latch the request
      logic search_read; // read the midpoint of the search bounds
      logic search_step; // one binary-search step
      logic search_init; // set search bounds
      logic shift_step;  // move one entry up during insert
      logic write_new;   // write the new value at its slot
      logic read_issue;  // issue the final memory read
      logic respond;     // form and strobe the answer
   } osm_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic search_done;
      logic shift_done;
      logic store_full;
      opcode_type opcode;
   } osm_status_type;
endpackage

// ===== rtl/osm_datapath.sv =====
// Datapath: sorted store memory, binary search bounds, shifter and answer logic.
module osm_datapath
   import osm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_opcode,
   input  logic                req_direction_up,
   input  logic signed [31:0]  req_operand,
   input  osm_cmd_type         cmd,
   output osm_status_type      status,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_answer
);
   logic signed [31:0] mem [Capacity];
   logic signed [31:0] rdata_ff;
   logic [1:0] op_ff;
   logic up_ff;
   logic signed [31:0] key_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CountWidth-1:0] ptr_ff, ptr_in;
   logic strict_w, go_right, sel_ok;
   logic [CountWidth-1:0] mid, rd_idx;
   logic [AddrWidth-1:0] rd_addr;
   logic rd_en, wr_en;
   logic [AddrWidth-1:0] wr_addr;
   logic signed [31:0] wr_data;
   logic [CountWidth-1:0] span;
   logic signed [31:0] ans;
   logic [CountWidth-1:0] kidx;

   // Insert and successor search for the first entry above the key.
   assign strict_w = (op_ff == OP_INSERT) || (op_ff == OP_NEIGH && up_ff);
   assign span = hi_ff - lo_ff;
   assign mid = lo_ff + (span >> 1);
   assign go_right = strict_w ? (rdata_ff <= key_ff) : (rdata_ff < key_ff);
   assign kidx = key_ff[CountWidth-1:0] - CountWidth'(1);
   assign sel_ok = (key_ff >= 32'sd1) && (key_ff <= $signed({1'b0, 31'(count_ff)}));

   // Search alternates: read mid (odd phase), then compare (search_step).
   // Insert reads the top entry in the fetch, then each shift writes the held word
   // one slot up while reading the word below the next destination.
   always_comb begin
      rd_en = 1'b0;
      rd_idx = mid;
      if (cmd.search_read) begin
         rd_en = 1'b1;
      end
      if (cmd.read_issue) begin
         rd_en = 1'b1;
         unique case (opcode_type'(op_ff))
            OP_SELECT: rd_idx = kidx;
            OP_NEIGH:  rd_idx = up_ff ? lo_ff : lo_ff - CountWidth'(1);
            OP_INSERT: rd_idx = count_ff - CountWidth'(1);
            default:   rd_idx = mid;
         endcase
      end
      if (cmd.shift_step) begin
         rd_en = 1'b1;
         rd_idx = ptr_ff - CountWidth'(2);
      end
      rd_addr = rd_idx[AddrWidth-1:0];
   end

   always_comb begin
      wr_en = cmd.write_new || cmd.search_step && 1'b0;
      wr_addr = lo_ff[AddrWidth-1:0];
      wr_data = key_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[rd_addr];
      if (cmd.shift_step && ptr_ff != lo_ff) begin
         mem[ptr_ff[AddrWidth-1:0]] <= rdata_ff;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      count_in = count_ff;
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.search_step) begin
         if (go_right) lo_in = mid + CountWidth'(1);
         else hi_in = mid;
      end
      if (cmd.read_issue && op_ff == OP_INSERT) ptr_in = count_ff;
      if (cmd.shift_step && ptr_ff != lo_ff) ptr_in = ptr_ff - CountWidth'(1);
      if (cmd.write_new) count_in = count_ff + CountWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ptr_ff <= ptr_in;
      if (cmd.capture) begin
         op_ff <= req_opcode;
         up_ff <= req_direction_up;
         key_ff <= req_operand;
      end
   end

   always_comb begin
      ans = TopSentinel;
      case (opcode_type'(op_ff))
         OP_RANK:   ans = $signed({1'b0, 31'(lo_ff)}) + 32'sd1;
         OP_SELECT: ans = sel_ok ? rdata_ff : TopSentinel;
         OP_NEIGH: begin
            if (up_ff) ans = (lo_ff < count_ff) ? rdata_ff : TopSentinel;
            else ans = (lo_ff != '0) ? rdata_ff : BottomSentinel;
         end
         default:   ans = TopSentinel;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= cmd.respond;
      if (cmd.respond) rsp_answer <= ans;
   end

   assign status.search_done = (lo_ff >= hi_ff);
   assign status.shift_done = (ptr_ff == lo_ff);
   assign status.store_full = (count_ff >= CountWidth'(Capacity));
   assign status.opcode = opcode_type'(op_ff);
endmodule

// ===== rtl/osm_controller.sv =====
// Controller: sequences search, insert shifting and the response.
module osm_controller
   import osm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  osm_status_type status,
   output osm_cmd_type    cmd
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_INIT  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_CMP   = 7'b0001000,
      ST_FETCH = 7'b0010000,
      ST_SHIFT = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (status.opcode == OP_INSERT && status.store_full) begin
               state_in = ST_IDLE;
            end else begin
               cmd.search_init = 1'b1;
               state_in = (status.opcode == OP_SELECT) ? ST_FETCH : ST_READ;
            end
         end
         ST_READ: begin
            // Issue the read of the midpoint (rd_idx defaults to mid).
            if (status.search_done) begin
               state_in = ST_FETCH;
            end else begin
               cmd.search_read = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.search_step = 1'b1;
            state_in = ST_READ;
         end
         ST_FETCH: begin
            cmd.read_issue = 1'b1;
            state_in = (status.opcode == OP_INSERT) ? ST_SHIFT : ST_DONE;
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (status.shift_done) begin
               cmd.write_new = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            cmd.respond = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

// ===== rtl/order_statistic_multiset.sv =====
// Top level of the order statistic multiset: controller plus datapath.
// Search: at most ceil(log2(n+1)) steps with n entries stored; each step reads, then compares.
// Insert: search, fetch, then one entry moved per cycle; a full store drops the insert.
// Rank, predecessor, successor: search, fetch, then the answer strobe; select skips the search.
// One transaction at a time; busy falls as the strobe rises. Synchronous reset empties the
// store; the receiver cannot stall the response strobe.
module order_statistic_multiset
   import osm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic               req_direction_up,
   input  logic signed [31:0] req_operand,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_answer
);
   osm_cmd_type cmd;
   osm_status_type status;

   osm_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .status(status), .cmd(cmd)
   );

   osm_datapath u_dp (
      .clock(clock), .reset(reset), .req_opcode(req_opcode),
      .req_direction_up(req_direction_up), .req_operand(req_operand),
      .cmd(cmd), .status(status), .rsp_valid(rsp_valid), .rsp_answer(rsp_answer)
   );
endmodule

// ===== rtl/osm_checker.sv =====
// Port-level checker for the order statistic multiset, bound to the top level.
`include "order_statistic_multiset_defines.svh"
module osm_checker
   import osm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_opcode,
   input logic               rsp_valid
);
   logic accept_w;
   logic insert_accept_w;

   assign accept_w = start && !busy;
   assign insert_accept_w = accept_w && (req_opcode == OP_INSERT);

   `OSM_ASSERT_NEXT(a_accept_busy, clock, reset, accept_w, busy, "accept without busy")
   `OSM_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "strobe too long")
   `OSM_ASSERT_IMPL(a_strobe_while_busy, clock, reset, rsp_valid, $past(busy), "stray response")
   `OSM_ASSERT_NEXT(a_insert_silent, clock, reset, insert_accept_w, !rsp_valid, "insert answered")
   `OSM_ASSERT_IMPL(a_idle_on_strobe, clock, reset, rsp_valid, !busy, "busy during strobe")
endmodule

bind order_statistic_multiset osm_checker u_osm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_opcode(req_opcode), .rsp_valid(rsp_valid)
);

// ===== tb/tb_order_statistic_multiset.sv =====
// Testbench for the order statistic multiset: rank, select, neighbor queries and inserts.
module tb_order_statistic_multiset;
   import osm_pkg::*;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic               req_direction_up;
   logic signed [31:0] req_operand;
   logic               rsp_valid;
   logic signed [31:0] rsp_answer;

   order_statistic_multiset u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_direction_up(req_direction_up),
      .req_operand(req_operand), .rsp_valid(rsp_valid), .rsp_answer(rsp_answer)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // predictor state: sorted contents of the store
   logic signed [31:0] model_values[$];
   logic signed [31:0] expected_answers[$];
   int error_count;
   int sent_count;
   int answer_count;
   int send_idle_pct;

   function automatic int count_below(logic signed [31:0] key, bit strict);
      int n;
      n = 0;
      foreach (model_values[i]) begin
         if (strict ? (model_values[i] <= key) : (model_values[i] < key)) n++;
      end
      return n;
   endfunction

   // work out the answer, update the predicted store; return 1 if an answer is due
   function automatic bit predict_answer(opcode_type op, logic up, logic signed [31:0] x,
                                         output logic signed [31:0] ans);
      int pos;
      ans = '0;
      case (op)
         OP_INSERT: begin
            if (model_values.size() < Capacity) begin
               pos = count_below(x, 1'b1);
               model_values.insert(pos, x);
            end
            return 1'b0;
         end
         OP_RANK: ans = count_below(x, 1'b0) + 1;
         OP_SELECT: begin
            if (x >= 1 && x <= model_values.size()) ans = model_values[x - 1];
            else ans = TopSentinel;
         end
         default: begin
            if (!up) begin
               pos = count_below(x, 1'b0);
               ans = (pos > 0) ? model_values[pos - 1] : BottomSentinel;
            end else begin
               pos = count_below(x, 1'b1);
               ans = (pos < model_values.size()) ? model_values[pos] : TopSentinel;
            end
         end
      endcase
      return 1'b1;
   endfunction

   task automatic send_transaction(opcode_type op, logic up, logic signed [31:0] x);
      logic signed [31:0] ans;
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_direction_up <= up;
      req_operand <= x;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (predict_answer(op, up, x, ans)) expected_answers = {expected_answers, ans};
      sent_count++;
      start <= 1'b0;
      req_opcode <= 2'($urandom);
      req_direction_up <= 1'($urandom);
      req_operand <= $urandom;
      // the block stays busy for at least this cycle
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         answer_count++;
         if (expected_answers.size() == 0) begin
            $error("rsp_answer with nothing expected: actual %0d", rsp_answer);
            error_count++;
         end else begin
            if (rsp_answer !== expected_answers[0]) begin
               $error("rsp_answer mismatch: expected %0d actual %0d",
                      expected_answers[0], rsp_answer);
               error_count++;
            end
            void'(expected_answers.pop_front());
         end
      end
   end

   task automatic drain_answers();
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(3))
         0: return $urandom_range(20) - 10;
         1: return $urandom;
         2: return $urandom_range(1) ? TopSentinel : 32'sh80000000;
         default: return $urandom_range(200) - 100;
      endcase
   endfunction

   function automatic logic signed [31:0] random_query();
      logic signed [31:0] v;
      v = random_value();
      // half the time aim at stored values and their neighbors
      if (model_values.size() != 0 && $urandom_range(1)) begin
         v = model_values[$urandom_range(model_values.size() - 1)];
         v = v + $signed($urandom_range(2)) - 1;
      end
      return v;
   endfunction

   task automatic test_empty_store();
      send_transaction(OP_RANK, 1'b0, 0);
      send_transaction(OP_SELECT, 1'b0, 1);
      send_transaction(OP_NEIGH, 1'b0, 0);
      send_transaction(OP_NEIGH, 1'b1, 0);
   endtask

   task automatic test_directed();
      send_transaction(OP_INSERT, 1'b0, 5);
      send_transaction(OP_INSERT, 1'b1, 5);
      send_transaction(OP_INSERT, 1'b0, TopSentinel);
      send_transaction(OP_INSERT, 1'b0, BottomSentinel);
      send_transaction(OP_INSERT, 1'b0, 32'sh80000000);
      send_transaction(OP_INSERT, 1'b0, -3);
      send_transaction(OP_RANK, 1'b0, 5);
      send_transaction(OP_RANK, 1'b1, 32'sh80000000);
      send_transaction(OP_RANK, 1'b0, TopSentinel);
      send_transaction(OP_SELECT, 1'b0, 0);
      send_transaction(OP_SELECT, 1'b0, 1);
      send_transaction(OP_SELECT, 1'b0, 6);
      send_transaction(OP_SELECT, 1'b0, 7);
      send_transaction(OP_SELECT, 1'b0, -1);
      send_transaction(OP_SELECT, 1'b0, 32'sh80000000);
      send_transaction(OP_NEIGH, 1'b0, 5);
      send_transaction(OP_NEIGH, 1'b1, 5);
      send_transaction(OP_NEIGH, 1'b0, 32'sh80000000);
      send_transaction(OP_NEIGH, 1'b1, TopSentinel);
      send_transaction(OP_NEIGH, 1'b0, 32'sh80000001);
      // hold until every answer is back
      drain_answers();
   endtask

   task automatic test_random(int items);
      opcode_type op;
      repeat (items) begin
         op = opcode_type'($urandom_range(3));
         if (op == OP_SELECT) begin
            if ($urandom_range(3) == 0) send_transaction(op, 1'($urandom), random_value());
            else send_transaction(op, 1'($urandom), $urandom_range(model_values.size() + 1));
         end else if (op == OP_INSERT) begin
            send_transaction(op, 1'($urandom), random_value());
         end else begin
            send_transaction(op, 1'($urandom), random_query());
         end
      end
   endtask

   initial begin
      error_count = 0;
      sent_count = 0;
      answer_count = 0;
      send_idle_pct = 36;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_INSERT;
      req_direction_up = 1'b0;
      req_operand = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_directed();
      test_random(220);
      send_idle_pct = 70;
      test_random(200);
      send_idle_pct = 0;
      test_random(200);
      drain_answers();
      repeat (50) @(posedge clock);
      $display("Covered %0d transactions, %0d answers, final store size %0d.",
               sent_count, answer_count, model_values.size());
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #60000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
